// ----- rtl/mcfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_pkg: shared types and constants of the frame responder
// Frame constants, request and state codes, and the command word that goes
// from the parser to the frame emitter.
// ----------------------------------------------------------------------------
package mcfr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned TOUCH_W   = 10;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned EEPROM_W  = 16;

    // Emitted payloads never exceed four bytes.
    localparam int unsigned PAY_LEN_W = 3;
    localparam int unsigned PAY_W     = 32;
    // Byte position inside an emitted frame, 0 up to six.
    localparam int unsigned POS_W     = 3;

    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PTR_W = 2;
    localparam int unsigned CMD_CNT_W = 3;

    localparam logic [BYTE_W-1:0]   SOF_BYTE   = 8'h02;
    localparam logic [NIBBLE_W-1:0] ID_VERSION = 4'h0;
    localparam logic [NIBBLE_W-1:0] ID_TOUCH   = 4'h3;
    localparam logic [NIBBLE_W-1:0] ID_EEPROM  = 4'h4;
    localparam logic [NIBBLE_W-1:0] ID_BATTERY = 4'h9;

    localparam logic [PAY_LEN_W-1:0] LEN_NONE   = 3'd0;
    localparam logic [PAY_LEN_W-1:0] LEN_EEPROM = 3'd2;
    localparam logic [PAY_LEN_W-1:0] LEN_FULL   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EEPROM  = 2'd2;

    localparam logic [CFG_W-1:0]    VERSION_RESET = 32'h312E3737;
    localparam logic [CFG_W-1:0]    BATTERY_RESET = 32'h01000F01;
    localparam logic [EEPROM_W-1:0] EEPROM_RESET  = 16'hFFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_HOST    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_kind_t;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_HDR   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CKSUM = 4'b1000
    } phase_t;

    // One frame to emit: id, payload length and up to four payload bytes,
    // first byte in the top octet.
    typedef struct packed {
        logic [NIBBLE_W-1:0]  id;
        logic [PAY_LEN_W-1:0] len;
        logic [PAY_W-1:0]     payload;
    } cmd_t;

endpackage

// ----- rtl/mcfr_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_req_if: request channel
// Host bytes and touch events toward the frame responder.
// ----------------------------------------------------------------------------
interface mcfr_req_if
    import mcfr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [BYTE_W-1:0]  host_byte;
    logic [TOUCH_W-1:0] touch_x;
    logic [TOUCH_W-1:0] touch_y;

    modport source (output valid, req_type, host_byte, touch_x, touch_y, input ready);
    modport sink   (input valid, req_type, host_byte, touch_x, touch_y, output ready);
endinterface

// ----- rtl/mcfr_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_rsp_if: reply channel
// Bytes of emitted frames toward the host, with a frame end mark.
// ----------------------------------------------------------------------------
interface mcfr_rsp_if
    import mcfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// ----- rtl/mcfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_front: request parser
// Holds the configuration words, parses host frames and turns replies and
// touch events into frame commands for the queue.
// ----------------------------------------------------------------------------
module mcfr_front
    import mcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mcfr_req_if.sink             req,
    input  logic                 cmd_full,
    output logic                 cmd_push,
    output cmd_t                 cmd_data
);

    logic [CFG_W-1:0]    version_reg;
    logic [CFG_W-1:0]    battery_reg;
    logic [EEPROM_W-1:0] eeprom_reg;

    phase_t              phase_reg, phase_next;
    logic [NIBBLE_W-1:0] id_reg, id_next;
    logic [NIBBLE_W-1:0] len_reg, len_next;
    logic [NIBBLE_W-1:0] seen_reg, seen_next;
    logic [NIBBLE_W-1:0] seen_inc;
    logic                accept;
    cmd_t                reply_cmd;

    assign req.ready = !cmd_full;
    assign accept    = req.valid && req.ready;
    assign seen_inc  = seen_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_RESET;
            battery_reg <= BATTERY_RESET;
            eeprom_reg  <= EEPROM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERSION: version_reg <= cfg_data;
                CFG_BATTERY: battery_reg <= cfg_data;
                CFG_EEPROM:  eeprom_reg  <= cfg_data[EEPROM_W-1:0];
                default:     ;
            endcase
        end
    end

    // Reply to the frame that has just been parsed.
    always_comb
    begin
        reply_cmd.id      = id_reg;
        reply_cmd.len     = LEN_NONE;
        reply_cmd.payload = '0;
        unique case (id_reg)
            ID_VERSION:
            begin
                reply_cmd.len     = LEN_FULL;
                reply_cmd.payload = version_reg;
            end
            ID_EEPROM:
            begin
                reply_cmd.len     = LEN_EEPROM;
                reply_cmd.payload = {eeprom_reg, {(PAY_W-EEPROM_W){1'b0}}};
            end
            ID_BATTERY:
            begin
                reply_cmd.len     = LEN_FULL;
                reply_cmd.payload = battery_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        cmd_push   = 1'b0;
        cmd_data   = reply_cmd;
        if (accept)
        begin
            unique case (req_kind_t'(req.req_type))
                REQ_PRESS:
                begin
                    cmd_push         = 1'b1;
                    cmd_data.id      = ID_TOUCH;
                    cmd_data.len     = LEN_FULL;
                    cmd_data.payload = {6'd0, req.touch_y[9:8], req.touch_y[7:0],
                                        6'd0, req.touch_x[9:8], req.touch_x[7:0]};
                end
                REQ_RELEASE:
                begin
                    cmd_push         = 1'b1;
                    cmd_data.id      = ID_TOUCH;
                    cmd_data.len     = LEN_NONE;
                    cmd_data.payload = '0;
                end
                REQ_HOST:
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            if (req.host_byte == SOF_BYTE)
                            begin
                                phase_next = PH_HDR;
                            end
                        end
                        PH_HDR:
                        begin
                            id_next    = req.host_byte[7:4];
                            len_next   = req.host_byte[3:0];
                            seen_next  = '0;
                            phase_next = (req.host_byte[3:0] == 4'd0) ? PH_CKSUM : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            seen_next = seen_inc;
                            if (seen_inc >= len_reg)
                            begin
                                phase_next = PH_CKSUM;
                            end
                        end
                        PH_CKSUM:
                        begin
                            phase_next = PH_WAIT;
                            cmd_push   = 1'b1;
                        end
                        default: phase_next = PH_WAIT;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            id_reg    <= '0;
            len_reg   <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_sof_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_HOST && phase_reg == PH_WAIT
            && req.host_byte == SOF_BYTE |=> phase_reg == PH_HDR)
        else $error("start byte did not open a frame");
`endif

endmodule

// ----- rtl/mcfr_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_cmd_fifo: frame command queue
// A short queue of frame commands between the parser and the emitter.
// ----------------------------------------------------------------------------
module mcfr_cmd_fifo
    import mcfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CMD_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count beyond depth");
`endif

endmodule

// ----- rtl/mcfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcfr_back: frame emitter
// Takes frame commands and sends start byte, header, payload and additive
// checksum one byte per cycle while rsp is ready, through an output register.
// ----------------------------------------------------------------------------
module mcfr_back
    import mcfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmd_t     head,
    input  logic     empty,
    output logic     pop,
    mcfr_rsp_if.source rsp
);

    logic              active_reg, active_next;
    cmd_t              cmd_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_end_reg;

    logic              emit;
    logic              last;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] cur_byte;
    logic [1:0]        pay_sel;
    logic [BYTE_W-1:0] pay_byte;

    assign emit    = active_reg && (!out_valid_reg || rsp.ready);
    assign last    = (pos_reg == cmd_reg.len + POS_W'(2));
    assign hdr     = {cmd_reg.id, 1'b0, cmd_reg.len};
    assign pay_sel = 2'(pos_reg - POS_W'(2));
    assign pop     = (!active_reg || (emit && last)) && !empty;

    always_comb
    begin
        case (pay_sel)
            2'd0:    pay_byte = cmd_reg.payload[31:24];
            2'd1:    pay_byte = cmd_reg.payload[23:16];
            2'd2:    pay_byte = cmd_reg.payload[15:8];
            default: pay_byte = cmd_reg.payload[7:0];
        endcase
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (pos_reg == POS_W'(0))
        begin
            cur_byte = SOF_BYTE;
        end
        else if (pos_reg == POS_W'(1))
        begin
            cur_byte = hdr;
            sum_next = hdr;
        end
        else if (last)
        begin
            cur_byte = sum_reg;
        end
        else
        begin
            cur_byte = pay_byte;
            sum_next = sum_reg + pay_byte;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        if (pop)
        begin
            active_next = 1'b1;
            pos_next    = '0;
        end
        else if (emit)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (emit)
        begin
            sum_reg      <= sum_next;
            out_byte_reg <= cur_byte;
            out_end_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_byte  = out_byte_reg;
    assign rsp.frame_end = out_end_reg;

`ifndef SYNTHESIS
    a_frame_starts_sof: assert property (@(posedge clk) disable iff (!rst_n)
        emit && pos_reg == POS_W'(0) |=> out_valid_reg && out_byte_reg == SOF_BYTE
            && !out_end_reg)
        else $error("frame did not open with the start byte");

    a_end_closes_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last |=> out_end_reg && (!active_reg || pos_reg == POS_W'(0)))
        else $error("frame end not aligned with the end of a command");
`endif

endmodule

// ----- rtl/micro_controller_frame_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micro_controller_frame_responder: host frame parser and reply generator
// Parses host frames, answers version, EEPROM and battery requests from
// configuration words and reports touch events as frames.
// ----------------------------------------------------------------------------
// Use of the block:
// - req carries one word per request: a host byte, a touch press with x and
//   y, or a touch release. A word is taken whenever valid and ready are high.
// - rsp carries the emitted frames one byte per word; frame_end marks the
//   checksum byte that closes each frame.
// - cfg_we, cfg_index and cfg_data write the version, battery and EEPROM
//   reply words; the user must write only while the block is idle, unenforced.
// - The parser takes one request word per cycle as long as the command
//   queue (four frames deep) has room. A reply or touch frame reaches rsp
//   through the queue, the emitter's command register and the output register.
// - The emitter sends one byte per cycle while rsp is ready; a frame holds
//   three bytes when empty, up to seven with a four-byte payload.
//   Sustained throughput is set by this byte serializer.
// - When rsp stalls, the output register holds its byte, the emitter waits,
//   the queue fills and req.ready falls only once four frames are waiting.
// - Reset clears the parser to waiting for a start byte, empties the queue
//   and loads the default configuration words.
// ----------------------------------------------------------------------------
module micro_controller_frame_responder
    import mcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    mcfr_req_if.sink             req,
    mcfr_rsp_if.source           rsp
);

    // Frame commands between the parser and the emitter.
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_pop;
    cmd_t cmd_head;
    logic cmd_empty;
    logic cmd_full;

    // The parser classifies each request word and queues a frame command
    // for every reply or touch event.
    mcfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_in)
    );

    // The queue lets the parser keep taking words while a frame drains.
    mcfr_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .empty     (cmd_empty),
        .full      (cmd_full)
    );

    // The emitter turns each command into bytes with a running checksum.
    mcfr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (cmd_head),
        .empty (cmd_empty),
        .pop   (cmd_pop),
        .rsp   (rsp)
    );

endmodule
